[rtl/sbp_pkg.sv]
// Package: payload types and result codes of the servo bus packet parser.
`default_nettype none
package sbp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] BCAST_ID = 8'd254;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_PARAM  = 3'd1;
  localparam logic [2:0] EV_ACCEPT = 3'd2;
  localparam logic [2:0] EV_CSUM   = 3'd3;
  localparam logic [2:0] EV_REJECT = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] packet_id;
    logic       is_broadcast;
    logic [7:0] instruction_code;
    logic [5:0] param_index;
    logic [7:0] param_byte;
    logic [5:0] param_total;
    logic [7:0] skip_count;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/sbp_stream_if.sv]
// Interface: valid/ready stream channel carrying one payload beat.
`default_nettype none
interface sbp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/servo_bus_packet_parser.sv]
// Top level: byte-stream packet framer for the servo bus (header, id, length, params, checksum).
//
//   channel | dir | beat                         | handshake
//   in_chan | in  | sbp_pkg::in_item_t  (1 byte) | valid/ready
//   out_chan| out | sbp_pkg::out_item_t (event)  | valid/ready
//   cfg     | in  | device_id                    | cfg_we, no ready
//
// One result beat per input beat; out_chan.valid rises in the cycle after acceptance.
// A beat is taken every cycle while the result register is empty or being drained.
// in_chan.ready drops only while a result is held with out_chan.ready low.
// Synchronous active-low reset clears the parse state; device_id resets to 1.
`default_nettype none
module servo_bus_packet_parser #(
  parameter int RX_BUFFER_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sbp_stream_if.sink       in_chan,
  sbp_stream_if.source     out_chan,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  import sbp_pkg::*;

  localparam int CNT_W = (RX_BUFFER_SIZE > 2) ? $clog2(RX_BUFFER_SIZE) : 1;

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_ID     = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_INSTR  = 3'd4;
  localparam logic [2:0] PH_PARAMS = 3'd5;

  logic [7:0]       device_id_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [7:0]       instr_r, instr_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  logic             in_fire;
  logic [7:0]       c;
  logic [2:0]       ev;
  logic [7:0]       pbyte, skip;
  logic [CNT_W-1:0] pidx;
  logic [7:0]       pidx_w, total_w;
  logic             len_ok;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign c              = in_chan.data.rx_byte;

  assign len_ok = ((id_r == BCAST_ID) || (id_r == device_id_r)) && (c > 8'd1) &&
                  ({1'b0, c} < 9'(RX_BUFFER_SIZE));

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    total_nxt = total_r;
    instr_nxt = instr_r;
    seen_nxt  = seen_r;
    sum_nxt   = sum_r;
    ev        = EV_NONE;
    pidx      = '0;
    pbyte     = 8'd0;
    skip      = 8'd0;
    unique case (phase_r)
      PH_FIRST: begin
        if (c == HDR_BYTE) phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        phase_nxt = (c == HDR_BYTE) ? PH_ID : PH_FIRST;
      end
      PH_ID: begin
        if (c != HDR_BYTE) begin
          id_nxt    = c;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (len_ok) begin
          total_nxt = CNT_W'(c - 8'd2);
          seen_nxt  = '0;
          sum_nxt   = id_r + c;
          phase_nxt = PH_INSTR;
        end else begin
          ev        = EV_REJECT;
          skip      = c;
          phase_nxt = PH_FIRST;
        end
      end
      PH_INSTR: begin
        instr_nxt = c;
        sum_nxt   = sum_r + c;
        phase_nxt = PH_PARAMS;
      end
      PH_PARAMS: begin
        if (seen_r >= total_r) begin
          if (c == ~sum_r) begin
            ev        = EV_ACCEPT;
            phase_nxt = PH_FIRST;
          end else begin
            ev        = EV_CSUM;
            phase_nxt = (c == HDR_BYTE) ? PH_SECOND : PH_FIRST;
          end
        end else begin
          ev       = EV_PARAM;
          pidx     = seen_r;
          pbyte    = c;
          seen_nxt = seen_r + CNT_W'(1);
          sum_nxt  = sum_r + c;
        end
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
  end

  assign pidx_w  = 8'(pidx);
  assign total_w = 8'(total_nxt);

  always_comb begin
    out_data_nxt.event_res        = ev;
    out_data_nxt.packet_id        = id_nxt;
    out_data_nxt.is_broadcast     = (id_nxt == BCAST_ID);
    out_data_nxt.instruction_code = instr_nxt;
    out_data_nxt.param_index      = pidx_w[5:0];
    out_data_nxt.param_byte       = pbyte;
    out_data_nxt.param_total      = total_w[5:0];
    out_data_nxt.skip_count       = skip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= 8'd1;
      phase_r     <= PH_FIRST;
      id_r        <= 8'd0;
      total_r     <= '0;
      instr_r     <= 8'd0;
      seen_r      <= '0;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) device_id_r <= cfg_wdata;
      if (in_fire) begin
        phase_r <= phase_nxt;
        id_r    <= id_nxt;
        total_r <= total_nxt;
        instr_r <= instr_nxt;
        seen_r  <= seen_nxt;
        sum_r   <= sum_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

[rtl/sbp_checker.sv]
// Checker: port-level properties of the servo bus packet parser, bound to the top level.
`default_nettype none
module sbp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sbp_pkg::out_item_t out_data
);
  import sbp_pkg::*;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_broadcast_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_broadcast == (out_data.packet_id == BCAST_ID)))
    else $error("broadcast flag disagrees with packet id");

  a_skip_only_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res != EV_REJECT) |-> (out_data.skip_count == 8'd0))
    else $error("skip count set outside a length reject");

endmodule

bind servo_bus_packet_parser sbp_checker u_sbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
`default_nettype wire

[test/testbench.sv]
// Testbench: servo bus packet parser checked beat by beat against a predictor.
`timescale 1ns / 1ps

module testbench;
  import sbp_pkg::*;

  localparam int RX_BUF = 64;
  localparam int STALL_LIMIT = 1000;

  typedef enum logic [2:0] {
    ST_HDR1, ST_HDR2, ST_ID, ST_LEN, ST_INSTR, ST_PARAMS
  } rx_phase_e;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  sbp_stream_if #(.payload_t(in_item_t))  in_if ();
  sbp_stream_if #(.payload_t(out_item_t)) out_if ();

  servo_bus_packet_parser #(.RX_BUFFER_SIZE(RX_BUF)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  rx_phase_e  rx_phase    = ST_HDR1;
  logic [7:0] node_id     = 8'd1;
  logic [7:0] held_id     = '0;
  logic [7:0] held_total  = '0;
  logic [7:0] held_instr  = '0;
  logic [7:0] params_seen = '0;
  logic [7:0] run_sum     = '0;

  out_item_t   pending_events [$];
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned event_tally [5];
  int unsigned quiet_cycles;
  int unsigned hold_cycles;
  bit          hold_req;
  bit          idle_on;
  logic [7:0]  mid_id;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_item_t parse_byte(input logic [7:0] c);
    out_item_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (rx_phase)
      ST_HDR1: begin
        if (c == HDR_BYTE) rx_phase = ST_HDR2;
      end
      ST_HDR2: begin
        rx_phase = (c == HDR_BYTE) ? ST_ID : ST_HDR1;
      end
      ST_ID: begin
        if (c != HDR_BYTE) begin
          held_id  = c;
          rx_phase = ST_LEN;
        end
      end
      ST_LEN: begin
        if ((held_id == BCAST_ID || held_id == node_id) && c > 8'd1 && int'(c) < RX_BUF) begin
          held_total  = c - 8'd2;
          params_seen = '0;
          run_sum     = held_id + c;
          rx_phase    = ST_INSTR;
        end else begin
          r.event_res  = EV_REJECT;
          r.skip_count = c;
          rx_phase     = ST_HDR1;
        end
      end
      ST_INSTR: begin
        held_instr = c;
        run_sum    = run_sum + c;
        rx_phase   = ST_PARAMS;
      end
      ST_PARAMS: begin
        if (params_seen >= held_total) begin
          if (c == ~run_sum) begin
            r.event_res = EV_ACCEPT;
            rx_phase    = ST_HDR1;
          end else begin
            r.event_res = EV_CSUM;
            rx_phase    = (c == HDR_BYTE) ? ST_HDR2 : ST_HDR1;
          end
        end else begin
          r.event_res   = EV_PARAM;
          r.param_index = params_seen[5:0];
          r.param_byte  = c;
          params_seen   = params_seen + 8'd1;
          run_sum       = run_sum + c;
        end
      end
      default: begin
        rx_phase = ST_HDR1;
      end
    endcase
    r.packet_id        = held_id;
    r.is_broadcast     = (held_id == BCAST_ID);
    r.instruction_code = held_instr;
    r.param_total      = held_total[5:0];
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.data.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    pending_events.push_back(parse_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_node_id(input logic [7:0] v);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    node_id   = v;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit bad_sum,
                            input int unsigned extra_ff);
    logic [7:0]  sum;
    logic [7:0]  pb;
    logic [7:0]  cs;
    logic [7:0]  flip;
    int unsigned k;
    put_byte(HDR_BYTE);
    put_byte(HDR_BYTE);
    repeat (extra_ff) put_byte(HDR_BYTE);
    put_byte(id);
    put_byte(len);
    pb = 8'($urandom_range(0, 255));
    put_byte(pb);
    sum = id + len + pb;
    for (k = 2; k < len; k++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum + pb;
      put_byte(pb);
    end
    cs = ~sum;
    if (bad_sum) begin
      flip = 8'($urandom_range(1, 255));
      if (cs != HDR_BYTE && $urandom_range(0, 1) == 1) cs = HDR_BYTE;
      else cs = cs ^ flip;
    end
    put_byte(cs);
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  id;
    logic [7:0]  len;
    kind    = $urandom_range(0, 9);
    idle_on = ($urandom_range(0, 3) != 0);
    if (kind <= 6) begin
      id  = ($urandom_range(0, 1) == 1) ? node_id : BCAST_ID;
      len = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(2, RX_BUF - 1)
                                          : $urandom_range(2, 8));
      n   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      send_frame(id, len, $urandom_range(0, 5) == 0, n);
    end else if (kind == 7) begin
      case ($urandom_range(0, 2))
        0:       id = node_id;
        1:       id = BCAST_ID;
        default: id = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 4))
        0:       len = 8'd0;
        1:       len = 8'd1;
        2:       len = 8'(RX_BUF);
        3:       len = 8'hFF;
        default: len = 8'($urandom_range(0, 255));
      endcase
      put_byte(HDR_BYTE);
      put_byte(HDR_BYTE);
      put_byte(id);
      put_byte(len);
    end else if (kind == 8) begin
      put_byte(HDR_BYTE);
      put_byte(HDR_BYTE);
      repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_framing_corners();
    logic [7:0] corner_bytes [26] = '{
      8'hFF, 8'h00,
      8'hFF, 8'hFF, 8'h05, 8'h03,
      8'hFF, 8'hFF, 8'hFE, 8'h03, 8'h00, 8'h80, 8'hFF,
      8'hFF, 8'hFF, 8'h01, 8'h02, 8'h80, 8'h7C,
      8'hFF, 8'hFF, 8'h01, 8'h03, 8'h10, 8'hFF, 8'h00
    };
    // bad second header, foreign id, bad sum on FF, resync with extra FF, bad sum
    idle_on = 1'b1;
    foreach (corner_bytes[i]) put_byte(corner_bytes[i]);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 48;
    hold_req    = 1'b1;
    send_frame(BCAST_ID, 8'd30, 1'b0, 0);
    drain_results();
  endtask

  task automatic test_random_traffic(input logic [7:0] id, input int unsigned n_bytes);
    int unsigned target;
    write_node_id(id);
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_frame();
    drain_results();
  endtask

  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (idle_on && $urandom_range(0, 1) == 1) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    bit        bad;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      results_seen++;
      if (got.event_res < 3'd5) event_tally[got.event_res]++;
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_events.pop_front();
        bad  = (got.event_res !== want.event_res) || (got.packet_id !== want.packet_id) ||
               (got.is_broadcast !== want.is_broadcast) ||
               (got.instruction_code !== want.instruction_code) ||
               (got.param_index !== want.param_index) || (got.param_byte !== want.param_byte) ||
               (got.param_total !== want.param_total) || (got.skip_count !== want.skip_count);
        if (bad) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d expected ev=%0d id=%h bc=%b ins=%h idx=%0d pb=%h tot=%0d skip=%h",
                     results_seen, want.event_res, want.packet_id, want.is_broadcast,
                     want.instruction_code, want.param_index, want.param_byte,
                     want.param_total, want.skip_count);
            $display("result %0d actual   ev=%0d id=%h bc=%b ins=%h idx=%0d pb=%h tot=%0d skip=%h",
                     results_seen, got.event_res, got.packet_id, got.is_broadcast,
                     got.instruction_code, got.param_index, got.param_byte,
                     got.param_total, got.skip_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("** servo_bus_packet_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_framing_corners();
    test_backpressure();
    mid_id = 8'($urandom_range(2, 252));
    test_random_traffic(8'd0, 150);
    test_random_traffic(8'd253, 150);
    test_random_traffic(mid_id, 150);
    test_random_traffic(8'd1, 150);

    $display("%0d bytes in, %0d results: %0d params, %0d accepted, %0d bad sums, %0d rejects",
             bytes_sent, results_seen, event_tally[EV_PARAM], event_tally[EV_ACCEPT],
             event_tally[EV_CSUM], event_tally[EV_REJECT]);
    $display("node ids 1, 0, 253, %0d; random gaps on both sides and one long output hold",
             mid_id);
    if (fail_count == 0) begin
      $display("** servo_bus_packet_parser: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** servo_bus_packet_parser: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sbp_pkg.sv
rtl/sbp_stream_if.sv
rtl/servo_bus_packet_parser.sv
rtl/sbp_checker.sv
test/testbench.sv
